// ----- hw/rtl/text_console_char_writer_defines.svh -----
// ----------------------------------------------------------------------------
// text console char writer assertion macros
// shared property wrappers for the console writer checks
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication, held off during reset
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

// next-cycle implication, held off during reset
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants of the text console character writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int MEM_CELLS = 8192;

  localparam int ADDR_W = 13;
  localparam int DATA_W = 16;
  localparam int KIND_W = 3;
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CHK_W  = ADDR_W + 2;

  localparam int MAX_CMDS = 4;
  localparam int CNT_W    = $clog2(MAX_CMDS);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [KIND_W-1:0] OP_CELL   = 3'd0;
  localparam logic [KIND_W-1:0] OP_ROW    = 3'd1;
  localparam logic [KIND_W-1:0] OP_ALL    = 3'd2;
  localparam logic [KIND_W-1:0] OP_START  = 3'd3;
  localparam logic [KIND_W-1:0] OP_CURSOR = 3'd4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam logic [7:0]        ATTR_RESET  = 8'h07;
  localparam logic [DATA_W-1:0] ERASE_RESET = 16'h0720;

  // register indexes
  localparam logic REG_CHAR_ATTR  = 1'b0;
  localparam logic REG_ERASE_CELL = 1'b1;

  typedef enum logic [2:0] {
    CC_IGNORE,
    CC_BS,
    CC_DEL,
    CC_CR,
    CC_LF,
    CC_FF,
    CC_PRINT
  } char_class_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } cmd_t;

  // commands caused by one input item, cnt is count minus one
  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    cmd_t [MAX_CMDS-1:0]    cmds;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_if.sv -----
// ----------------------------------------------------------------------------
// tcw_in_if / tcw_out_if
// valid/ready channels of the text console character writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface tcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::KIND_W-1:0]     op_kind;
  logic [tcw_pkg::ADDR_W-1:0]     cell_addr;
  logic [tcw_pkg::DATA_W-1:0]     cell_data;
  logic                           last;

  modport source (output valid, output op_kind, output cell_addr, output cell_data,
                  output last, input ready);
  modport sink   (input valid, input op_kind, input cell_addr, input cell_data,
                  input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// accepts console requests, updates cursor state and builds command bundles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tcw_in_if.sink                             in_ch,
  input  wire logic [7:0]                    char_attr,
  input  wire logic [tcw_pkg::DATA_W-1:0]    erase_cell,
  input  wire tcw_pkg::q_stat_t              q_stat,
  output logic                               push,
  output tcw_pkg::bundle_t                   bundle
);

  localparam logic [tcw_pkg::ADDR_W-1:0] A_COLS = tcw_pkg::ADDR_W'(tcw_pkg::COLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] A_SCRL =
    tcw_pkg::ADDR_W'(tcw_pkg::ROWS * tcw_pkg::COLS);
  localparam logic [tcw_pkg::CHK_W-1:0]  C_NEED =
    tcw_pkg::CHK_W'((tcw_pkg::ROWS + 1) * tcw_pkg::COLS);
  localparam logic [tcw_pkg::CHK_W-1:0]  C_MEM  = tcw_pkg::CHK_W'(tcw_pkg::MEM_CELLS);
  localparam logic [tcw_pkg::COL_W-1:0]  COL_END = tcw_pkg::COL_W'(tcw_pkg::COLS);
  localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  logic [tcw_pkg::ADDR_W-1:0] ds_r, ds_nxt;
  logic [tcw_pkg::ADDR_W-1:0] cur_r, cur_nxt;
  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;

  tcw_pkg::char_class_t       cls;
  logic                       wrap;
  logic                       nl_do;
  logic                       last_row;
  logic                       scroll;
  logic [tcw_pkg::ADDR_W-1:0] nl_base;
  logic [tcw_pkg::ADDR_W-1:0] nl_cur;
  logic [tcw_pkg::ADDR_W-1:0] nl_ds;
  logic [tcw_pkg::ROW_W-1:0]  nl_row;
  logic [tcw_pkg::ADDR_W-1:0] col_a;
  logic [2:0]                 n;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    case (in_ch.char_code)
      tcw_pkg::CH_NUL, tcw_pkg::CH_BEL, tcw_pkg::CH_HT, tcw_pkg::CH_VT: cls = tcw_pkg::CC_IGNORE;
      tcw_pkg::CH_BS:  cls = tcw_pkg::CC_BS;
      tcw_pkg::CH_DEL: cls = tcw_pkg::CC_DEL;
      tcw_pkg::CH_CR:  cls = tcw_pkg::CC_CR;
      tcw_pkg::CH_LF:  cls = tcw_pkg::CC_LF;
      tcw_pkg::CH_FF:  cls = tcw_pkg::CC_FF;
      default:         cls = tcw_pkg::CC_PRINT;
    endcase
  end

  // newline shared by line feed, form feed and a pending wrap
  assign wrap     = (cls == tcw_pkg::CC_PRINT) && (col_r == COL_END);
  assign nl_do    = wrap || (cls == tcw_pkg::CC_LF) || (cls == tcw_pkg::CC_FF);
  assign nl_base  = wrap ? (cur_r - A_COLS) : cur_r;
  assign last_row = (row_r == ROW_LAST);
  assign scroll   = last_row && ((tcw_pkg::CHK_W'(ds_r) + C_NEED) <= C_MEM);
  assign nl_cur   = (!last_row || scroll) ? (nl_base + A_COLS) : nl_base;
  assign nl_ds    = scroll ? (ds_r + A_COLS) : ds_r;
  assign nl_row   = last_row ? row_r : (row_r + tcw_pkg::ROW_W'(1));
  assign col_a    = tcw_pkg::ADDR_W'(col_r);

  always_comb begin
    ds_nxt      = ds_r;
    cur_nxt     = cur_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    bundle.cmds = '0;
    n           = 3'd0;
    if (in_ch.req_type) begin
      ds_nxt  = '0;
      cur_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
      bundle.cmds[0] = '{tcw_pkg::OP_CURSOR, '0, '0};
      bundle.cmds[1] = '{tcw_pkg::OP_START, '0, '0};
      bundle.cmds[2] = '{tcw_pkg::OP_ALL, '0, erase_cell};
      n = 3'd3;
    end else begin
      if (nl_do) begin
        row_nxt = nl_row;
        ds_nxt  = nl_ds;
        cur_nxt = nl_cur;
        if (last_row) begin
          if (scroll) begin
            bundle.cmds[n[1:0]] = '{tcw_pkg::OP_ROW, ds_r + A_SCRL, erase_cell};
            n = n + 3'd1;
          end
          bundle.cmds[n[1:0]] = '{tcw_pkg::OP_START, nl_ds, '0};
          n = n + 3'd1;
        end
      end
      case (cls)
        tcw_pkg::CC_BS: begin
          if (col_r != '0) begin
            col_nxt = col_r - tcw_pkg::COL_W'(1);
            cur_nxt = cur_r - tcw_pkg::ADDR_W'(1);
            bundle.cmds[n[1:0]] = '{tcw_pkg::OP_CELL, cur_nxt, erase_cell};
            n = n + 3'd1;
          end
        end
        tcw_pkg::CC_DEL: begin
          bundle.cmds[n[1:0]] = '{tcw_pkg::OP_CELL, cur_r, erase_cell};
          n = n + 3'd1;
        end
        tcw_pkg::CC_CR: begin
          cur_nxt = cur_r - col_a;
          col_nxt = '0;
        end
        tcw_pkg::CC_LF: begin
          cur_nxt = nl_cur - col_a;
          col_nxt = '0;
        end
        tcw_pkg::CC_PRINT: begin
          bundle.cmds[n[1:0]] = '{tcw_pkg::OP_CELL, cur_nxt, {char_attr, in_ch.char_code}};
          n = n + 3'd1;
          cur_nxt = cur_nxt + tcw_pkg::ADDR_W'(1);
          col_nxt = (wrap ? '0 : col_r) + tcw_pkg::COL_W'(1);
        end
        default: begin
        end
      endcase
      bundle.cmds[n[1:0]] = '{tcw_pkg::OP_CURSOR, cur_nxt, '0};
      n = n + 3'd1;
    end
    bundle.cnt = tcw_pkg::CNT_W'(n - 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ds_r  <= '0;
      cur_r <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (push) begin
      ds_r  <= ds_nxt;
      cur_r <= cur_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue
// short bundle queue between the front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire tcw_pkg::bundle_t       wr_bundle,
  input  wire logic                   pop,
  output tcw_pkg::bundle_t            head,
  output tcw_pkg::q_stat_t            stat
);

  tcw_pkg::bundle_t [tcw_pkg::QDEPTH-1:0] mem_r;
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [tcw_pkg::QCNT_W-1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH));
  assign stat.valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                    : wr_ptr_r + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                    : rd_ptr_r + tcw_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + tcw_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - tcw_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// issues the commands of each queued bundle, one per cycle while the output is not stalled, into an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tcw_pkg::bundle_t       head,
  input  wire tcw_pkg::q_stat_t       q_stat,
  output logic                        pop,
  tcw_out_if.source                   out_ch
);

  logic [tcw_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic [tcw_pkg::KIND_W-1:0] kind_r;
  logic [tcw_pkg::ADDR_W-1:0] addr_r;
  logic [tcw_pkg::DATA_W-1:0] data_r;
  logic                       last_r;
  logic                       load;
  logic                       at_end;
  tcw_pkg::cmd_t              cur_cmd;

  assign load    = !valid_r || out_ch.ready;
  assign cur_cmd = head.cmds[idx_r];
  assign at_end  = (idx_r == head.cnt);
  assign pop     = load && q_stat.valid && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = q_stat.valid;
      if (q_stat.valid) begin
        idx_nxt = at_end ? '0 : idx_r + tcw_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_stat.valid) begin
      kind_r <= cur_cmd.kind;
      addr_r <= cur_cmd.addr;
      data_r <= cur_cmd.data;
      last_r <= at_end;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.op_kind   = kind_r;
  assign out_ch.cell_addr = addr_r;
  assign out_ch.cell_data = data_r;
  assign out_ch.last      = last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// text-mode console controller emitting video memory and crt commands
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry bundle queue has room;
// the front end updates display start, cursor, column and row at that transfer.
// Commands leave the output register at one per cycle while the output is ready
// and work is queued. An item makes 2 commands for a printable character, 1 to 2
// for control characters, 2 to 4 when a newline reaches the last row, 3 for a
// clear. The back-end command issue sets the sustained rate. char_attr sits at
// byte address 0 and erase_cell at 4; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_char_writer_defines.svh"

module text_console_char_writer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  tcw_in_if.sink                           in_ch,
  tcw_out_if.source                        out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [tcw_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [tcw_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tcw_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);

  logic [7:0]                 char_attr_r;
  logic [tcw_pkg::DATA_W-1:0] erase_cell_r;
  logic                       cfg_wr;

  logic                       push;
  logic                       pop;
  tcw_pkg::bundle_t           wr_bundle;
  tcw_pkg::bundle_t           head;
  tcw_pkg::q_stat_t           q_stat;

  logic                       in_xfer;
  logic                       out_fill_all;
  logic                       out_ends_item;
  logic                       out_last_ok;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_attr_r  <= tcw_pkg::ATTR_RESET;
      erase_cell_r <= tcw_pkg::ERASE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        tcw_pkg::REG_CHAR_ATTR:  char_attr_r  <= cfg_pwdata[7:0];
        tcw_pkg::REG_ERASE_CELL: erase_cell_r <= cfg_pwdata[tcw_pkg::DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      tcw_pkg::REG_CHAR_ATTR:  cfg_prdata = tcw_pkg::CFG_DW'(char_attr_r);
      tcw_pkg::REG_ERASE_CELL: cfg_prdata = tcw_pkg::CFG_DW'(erase_cell_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .char_attr  (char_attr_r),
    .erase_cell (erase_cell_r),
    .q_stat     (q_stat),
    .push       (push),
    .bundle     (wr_bundle)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  tcw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_fill_all  = out_ch.valid && (out_ch.op_kind == tcw_pkg::OP_ALL);
  assign out_ends_item = out_ch.valid && out_ch.last;
  assign out_last_ok   = (out_ch.op_kind == tcw_pkg::OP_CURSOR) ||
                         (out_ch.op_kind == tcw_pkg::OP_ALL);

  // a fill of all memory only ever closes a clear
  `TCW_ASSERT_IMPL(a_fill_all_last, clk, rst_n, out_fill_all, out_ch.last)
  // every item ends with a cursor update or the memory fill
  `TCW_ASSERT_IMPL(a_last_kind, clk, rst_n, out_ends_item, out_last_ok)
  // an accepted request leaves work queued
  `TCW_ASSERT_NEXT(a_push_queued, clk, rst_n, in_xfer, q_stat.valid)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams of console bytes and clear requests into the text console writer;
// a local console model predicts every memory and crt command, and the
// commands coming out are compared with it one transfer at a time
// ----------------------------------------------------------------------------
module tb;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [tcw_pkg::KIND_W-1:0] kind;
    logic [tcw_pkg::ADDR_W-1:0] addr;
    logic [tcw_pkg::DATA_W-1:0] data;
    logic                       last;
  } console_cmd_t;

  typedef struct {
    logic             req;
    logic [7:0]       ch;
    int               n_typed;
    logic [2:0][31:0] typed;
  } directed_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [tcw_pkg::CFG_AW-1:0] cfg_paddr;
  logic [tcw_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [tcw_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_char_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // console model state and its copy of the registers
  logic [tcw_pkg::ADDR_W-1:0] view_start;
  logic [tcw_pkg::ADDR_W-1:0] cursor_pos;
  logic [6:0]                 col_pos;
  logic [4:0]                 row_pos;
  logic [7:0]                 attr_reg;
  logic [tcw_pkg::DATA_W-1:0] erase_reg;

  console_cmd_t  item_cmds[$];
  console_cmd_t  console_cmds_due[$];
  directed_row_t directed_rows[$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_hold_left  = 0;
  int stall_cycles  = 0;
  bit rx_hold_go    = 1'b0;

  function automatic logic [31:0] cmd_word(logic [tcw_pkg::KIND_W-1:0] kind, int addr,
                                           logic [tcw_pkg::DATA_W-1:0] data);
    return {kind, tcw_pkg::ADDR_W'(addr), data};
  endfunction

  function automatic void add_row(logic req, logic [7:0] ch, int n = 0,
                                  logic [31:0] c0 = '0, logic [31:0] c1 = '0,
                                  logic [31:0] c2 = '0);
    directed_row_t r;
    r.req     = req;
    r.ch      = ch;
    r.n_typed = n;
    r.typed   = {c2, c1, c0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cmd(logic [tcw_pkg::KIND_W-1:0] kind,
                                  logic [tcw_pkg::ADDR_W-1:0] addr,
                                  logic [tcw_pkg::DATA_W-1:0] data);
    console_cmd_t c;
    c.kind = kind;
    c.addr = addr;
    c.data = data;
    c.last = 1'b0;
    item_cmds.push_back(c);
  endfunction

  function automatic void console_newline();
    if (int'(row_pos) + 1 < tcw_pkg::ROWS) begin
      row_pos    = row_pos + 1'b1;
      cursor_pos = cursor_pos + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
    end else begin
      // scroll only while a whole fresh row still fits in video memory
      if (int'(view_start) + (tcw_pkg::ROWS + 1) * tcw_pkg::COLS <= tcw_pkg::MEM_CELLS) begin
        add_cmd(tcw_pkg::OP_ROW,
                view_start + tcw_pkg::ADDR_W'(tcw_pkg::ROWS * tcw_pkg::COLS), erase_reg);
        view_start = view_start + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
        cursor_pos = cursor_pos + tcw_pkg::ADDR_W'(tcw_pkg::COLS);
      end
      add_cmd(tcw_pkg::OP_START, view_start, '0);
    end
  endfunction

  function automatic void console_line_start();
    cursor_pos = cursor_pos - tcw_pkg::ADDR_W'(col_pos);
    col_pos    = '0;
  endfunction

  function automatic void advance_console(logic req, logic [7:0] ch);
    item_cmds.delete();
    if (req) begin
      view_start = '0;
      cursor_pos = '0;
      col_pos    = '0;
      row_pos    = '0;
      add_cmd(tcw_pkg::OP_CURSOR, '0, '0);
      add_cmd(tcw_pkg::OP_START, '0, '0);
      add_cmd(tcw_pkg::OP_ALL, '0, erase_reg);
    end else begin
      case (ch)
        tcw_pkg::CH_NUL, tcw_pkg::CH_BEL, tcw_pkg::CH_HT, tcw_pkg::CH_VT: ;
        tcw_pkg::CH_BS: begin
          if (col_pos != 0) begin
            col_pos    = col_pos - 1'b1;
            cursor_pos = cursor_pos - 1'b1;
            add_cmd(tcw_pkg::OP_CELL, cursor_pos, erase_reg);
          end
        end
        tcw_pkg::CH_DEL: add_cmd(tcw_pkg::OP_CELL, cursor_pos, erase_reg);
        tcw_pkg::CH_CR:  console_line_start();
        tcw_pkg::CH_LF: begin
          console_newline();
          console_line_start();
        end
        tcw_pkg::CH_FF:  console_newline();
        default: begin
          // pending wrap: back to the row start, then a newline
          if (int'(col_pos) >= tcw_pkg::COLS) begin
            col_pos    = col_pos - 7'(tcw_pkg::COLS);
            cursor_pos = cursor_pos - tcw_pkg::ADDR_W'(tcw_pkg::COLS);
            console_newline();
          end
          add_cmd(tcw_pkg::OP_CELL, cursor_pos, {attr_reg, ch});
          cursor_pos = cursor_pos + 1'b1;
          col_pos    = col_pos + 1'b1;
        end
      endcase
      add_cmd(tcw_pkg::OP_CURSOR, cursor_pos, '0);
    end
  endfunction

  task automatic send_item(input logic req, input logic [7:0] ch, input int n_typed = 0,
                           input logic [2:0][31:0] typed = '0);
    console_cmd_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.char_code <= ch;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    advance_console(req, ch);
    if (n_typed > 0) begin
      item_cmds.delete();
      for (int i = 0; i < n_typed; i++)
        add_cmd(typed[i][31:29], typed[i][28:16], typed[i][15:0]);
    end
    foreach (item_cmds[i]) begin
      c      = item_cmds[i];
      c.last = (i == item_cmds.size() - 1);
      console_cmds_due.push_back(c);
    end
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (console_cmds_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [tcw_pkg::CFG_DW-1:0] value);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= tcw_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == tcw_pkg::REG_CHAR_ATTR) attr_reg = value[7:0];
    else                               erase_reg = value[tcw_pkg::DATA_W-1:0];
  endtask

  task automatic run_random_phase(input int n_items, input int tx_idle, input int rx_idle,
                                  input bit long_hold, input bit mid_pause);
    int         sent;
    int         seg;
    int         len;
    int         pick;
    bit         paused;
    logic       req;
    logic [7:0] ch;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    if (long_hold) rx_hold_go = 1'b1;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (mid_pause && !paused && sent >= n_items / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      // lines of text, newline runs that scroll, control bursts, odd noise
      seg = $urandom_range(99);
      if (seg < 45)      len = $urandom_range(1, 100);
      else if (seg < 80) len = $urandom_range(20, 60);
      else if (seg < 95) len = $urandom_range(1, 8);
      else               len = $urandom_range(1, 4);
      for (int k = 0; k < len && sent < n_items; k++) begin
        req = 1'b0;
        if (seg < 45) begin
          ch = 8'($urandom_range(8'h20, 8'hFF));
        end else if (seg < 80) begin
          pick = $urandom_range(9);
          ch   = (pick < 7) ? tcw_pkg::CH_LF : (pick < 9) ? tcw_pkg::CH_FF : tcw_pkg::CH_CR;
        end else if (seg < 95) begin
          case ($urandom_range(9))
            0:       ch = tcw_pkg::CH_NUL;
            1:       ch = tcw_pkg::CH_BEL;
            2:       ch = tcw_pkg::CH_BS;
            3:       ch = tcw_pkg::CH_HT;
            4:       ch = tcw_pkg::CH_LF;
            5:       ch = tcw_pkg::CH_VT;
            6:       ch = tcw_pkg::CH_FF;
            7:       ch = tcw_pkg::CH_CR;
            8:       ch = tcw_pkg::CH_DEL;
            default: ch = 8'($urandom_range(31));
          endcase
        end else begin
          req = ($urandom_range(2) == 0);
          ch  = 8'($urandom);
        end
        send_item(req, ch);
        sent++;
      end
    end
  endtask

  // result side: check each command transfer, then choose next ready
  always @(posedge clk) begin : result_check
    console_cmd_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (console_cmds_due.size() == 0) begin
        $display("%0t: unexpected command kind %0d addr %0d data %h last %b", $time,
                 out_if.op_kind, out_if.cell_addr, out_if.cell_data, out_if.last);
        errors++;
      end else begin
        want = console_cmds_due.pop_front();
        if (out_if.op_kind !== want.kind || out_if.cell_addr !== want.addr ||
            out_if.cell_data !== want.data || out_if.last !== want.last) begin
          $display("%0t: expected kind %0d addr %0d data %h last %b,", $time,
                   want.kind, want.addr, want.data, want.last);
          $display("  got kind %0d addr %0d data %h last %b",
                   out_if.op_kind, out_if.cell_addr, out_if.cell_data, out_if.last);
          errors++;
        end
      end
    end
    if (rx_hold_go) begin
      rx_hold_go   = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.req_type  = 1'b0;
    in_if.char_code = '0;
    out_if.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    view_start      = '0;
    cursor_pos      = '0;
    col_pos         = '0;
    row_pos         = '0;
    attr_reg        = tcw_pkg::ATTR_RESET;
    erase_reg       = tcw_pkg::ERASE_RESET;
    send_idle_pct   = 20;
    recv_idle_pct   = 20;

    add_row(1'b1, 8'h00, 3, cmd_word(tcw_pkg::OP_CURSOR, 0, '0),
            cmd_word(tcw_pkg::OP_START, 0, '0),
            cmd_word(tcw_pkg::OP_ALL, 0, tcw_pkg::ERASE_RESET));
    add_row(1'b0, 8'h41, 2, cmd_word(tcw_pkg::OP_CELL, 0, {tcw_pkg::ATTR_RESET, 8'h41}),
            cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, tcw_pkg::CH_NUL, 1, cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, tcw_pkg::CH_BEL, 1, cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, tcw_pkg::CH_HT, 1, cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, tcw_pkg::CH_VT, 1, cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, tcw_pkg::CH_BS, 2, cmd_word(tcw_pkg::OP_CELL, 0, tcw_pkg::ERASE_RESET),
            cmd_word(tcw_pkg::OP_CURSOR, 0, '0));
    // backspace at column zero only reports the cursor
    add_row(1'b0, tcw_pkg::CH_BS, 1, cmd_word(tcw_pkg::OP_CURSOR, 0, '0));
    add_row(1'b0, tcw_pkg::CH_DEL, 2, cmd_word(tcw_pkg::OP_CELL, 0, tcw_pkg::ERASE_RESET),
            cmd_word(tcw_pkg::OP_CURSOR, 0, '0));
    add_row(1'b0, 8'hFF, 2, cmd_word(tcw_pkg::OP_CELL, 0, {tcw_pkg::ATTR_RESET, 8'hFF}),
            cmd_word(tcw_pkg::OP_CURSOR, 1, '0));
    add_row(1'b0, 8'h80, 2, cmd_word(tcw_pkg::OP_CELL, 1, {tcw_pkg::ATTR_RESET, 8'h80}),
            cmd_word(tcw_pkg::OP_CURSOR, 2, '0));
    add_row(1'b0, tcw_pkg::CH_CR, 1, cmd_word(tcw_pkg::OP_CURSOR, 0, '0));
    add_row(1'b0, tcw_pkg::CH_LF, 1, cmd_word(tcw_pkg::OP_CURSOR, tcw_pkg::COLS, '0));
    add_row(1'b0, tcw_pkg::CH_FF, 1, cmd_word(tcw_pkg::OP_CURSOR, 2 * tcw_pkg::COLS, '0));
    add_row(1'b0, 8'h20, 2,
            cmd_word(tcw_pkg::OP_CELL, 2 * tcw_pkg::COLS, {tcw_pkg::ATTR_RESET, 8'h20}),
            cmd_word(tcw_pkg::OP_CURSOR, 2 * tcw_pkg::COLS + 1, '0));
    add_row(1'b0, 8'h7E, 2,
            cmd_word(tcw_pkg::OP_CELL, 2 * tcw_pkg::COLS + 1, {tcw_pkg::ATTR_RESET, 8'h7E}),
            cmd_word(tcw_pkg::OP_CURSOR, 2 * tcw_pkg::COLS + 2, '0));
    add_row(1'b0, tcw_pkg::CH_FF);
    add_row(1'b0, 8'h61);
    add_row(1'b0, tcw_pkg::CH_DEL);
    // clear ignores the character byte
    add_row(1'b1, 8'hFF, 3, cmd_word(tcw_pkg::OP_CURSOR, 0, '0),
            cmd_word(tcw_pkg::OP_START, 0, '0),
            cmd_word(tcw_pkg::OP_ALL, 0, tcw_pkg::ERASE_RESET));
    add_row(1'b0, 8'h1F);
    add_row(1'b0, 8'h0E);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].ch, directed_rows[i].n_typed,
                directed_rows[i].typed);

    write_reg(tcw_pkg::REG_CHAR_ATTR, 32'h0000_0000);
    write_reg(tcw_pkg::REG_ERASE_CELL, 32'h0000_0000);
    run_random_phase(100, 32, 72, 1'b1, 1'b0);

    write_reg(tcw_pkg::REG_CHAR_ATTR, 32'h0000_00FF);
    write_reg(tcw_pkg::REG_ERASE_CELL, 32'h0000_FFFF);
    run_random_phase(100, 72, 32, 1'b0, 1'b1);

    write_reg(tcw_pkg::REG_CHAR_ATTR, 32'($urandom_range(255)));
    write_reg(tcw_pkg::REG_ERASE_CELL, 32'($urandom_range(16'hFFFF)));
    run_random_phase(100, 0, 0, 1'b0, 1'b0);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else             $display("tb NOT OK");
    $finish;
  end

endmodule
